// ----- sv/wbss_pkg.sv -----
package wbss_pkg;

    // Signature geometry
    localparam int MAX_SIG_BYTES = 16;
    localparam int HIST_DEPTH    = MAX_SIG_BYTES - 1;
    localparam int LEN_W         = 5;
    localparam int POS_W         = $clog2(MAX_SIG_BYTES);
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 64;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SIG_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIG_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WILDCARD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SIG_LEN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MATCH_IDX = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ADDR_OFS = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BASE     = 3'd6;

    // Register contents as seen by the datapath
    typedef struct packed {
        logic [63:0]              sig_low;
        logic [63:0]              sig_high;
        logic [MAX_SIG_BYTES-1:0] wild_mask;
        logic [LEN_W-1:0]         sig_len;
        logic [31:0]              match_idx;
        logic [31:0]              addr_bias;  // base_address + address_offset
    } cfg_t;

    // One result item
    typedef struct packed {
        logic        window_match;
        logic [31:0] match_start;
        logic [31:0] matches_so_far;
        logic        end_of_buffer;
        logic        requested_found;
        logic [31:0] requested_address;
    } res_t;

endpackage

// ----- sv/wbss_ifs.sv -----
// Byte stream channel
interface wbss_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// Result channel
interface wbss_out_if;
    logic        valid;
    logic        ready;
    logic        window_match;
    logic [31:0] match_start;
    logic [31:0] matches_so_far;
    logic        end_of_buffer;
    logic        requested_found;
    logic [31:0] requested_address;

    modport source (output valid, output window_match, output match_start,
                    output matches_so_far, output end_of_buffer,
                    output requested_found, output requested_address, input ready);
    modport sink   (input valid, input window_match, input match_start,
                    input matches_so_far, input end_of_buffer,
                    input requested_found, input requested_address, output ready);
endinterface

// Register write channel
interface wbss_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- sv/wbss_cfg.sv -----
module wbss_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             wr_en,
    input  logic [wbss_pkg::CFG_IDX_W-1:0]   wr_index,
    input  logic [wbss_pkg::CFG_DATA_W-1:0]  wr_data,
    output wbss_pkg::cfg_t                   cfg
);
    import wbss_pkg::*;

    logic [63:0]              sig_low_reg;
    logic [63:0]              sig_high_reg;
    logic [MAX_SIG_BYTES-1:0] wild_reg;
    logic [LEN_W-1:0]         len_reg;
    logic [31:0]              idx_reg;
    logic [31:0]              ofs_reg;
    logic [31:0]              base_reg;
    logic [31:0]              bias_reg;

    // Register file; base plus offset is kept pre-added
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sig_low_reg  <= '0;
            sig_high_reg <= '0;
            wild_reg     <= '0;
            len_reg      <= LEN_W'(1);
            idx_reg      <= '0;
            ofs_reg      <= '0;
            base_reg     <= '0;
            bias_reg     <= '0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_SIG_LOW:   sig_low_reg  <= wr_data;
                REG_SIG_HIGH:  sig_high_reg <= wr_data;
                REG_WILDCARD:  wild_reg     <= wr_data[MAX_SIG_BYTES-1:0];
                REG_SIG_LEN:   len_reg      <= wr_data[LEN_W-1:0];
                REG_MATCH_IDX: idx_reg      <= wr_data[31:0];
                REG_ADDR_OFS:
                begin
                    ofs_reg  <= wr_data[31:0];
                    bias_reg <= base_reg + wr_data[31:0];
                end
                REG_BASE:
                begin
                    base_reg <= wr_data[31:0];
                    bias_reg <= wr_data[31:0] + ofs_reg;
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        cfg.sig_low   = sig_low_reg;
        cfg.sig_high  = sig_high_reg;
        cfg.wild_mask = wild_reg;
        cfg.sig_len   = len_reg;
        cfg.match_idx = idx_reg;
        cfg.addr_bias = bias_reg;
    end

endmodule

// ----- sv/wbss_core.sv -----
module wbss_core (
    input  logic            clk,
    input  logic            rst_n,
    input  wbss_pkg::cfg_t  cfg,
    input  logic            step,
    input  logic [7:0]      data_byte,
    input  logic            last_byte,
    output wbss_pkg::res_t  res
);
    import wbss_pkg::*;

    localparam logic [31:0] MAX32 = '1;

    logic [7:0]  hist_reg [HIST_DEPTH];
    logic [31:0] pos_reg;
    logic [31:0] cnt_reg;
    logic        req_hit_reg;
    logic [31:0] req_start_reg;

    logic [LEN_W-1:0]         len;
    logic [POS_W-1:0]         len_m1;
    logic [7:0]               win [MAX_SIG_BYTES];
    logic [7:0]               sig [MAX_SIG_BYTES];
    logic [MAX_SIG_BYTES-1:0] lane_ok;
    logic [POS_W-1:0]         k;
    logic                     hit;
    logic [31:0]              start;
    logic                     capture;
    logic [31:0]              cnt_next;
    logic [31:0]              pos_next;
    logic                     req_hit_next;
    logic [31:0]              req_start_next;
    logic                     found;

    // Clamp length to 1..MAX_SIG_BYTES
    always_comb
    begin
        if (cfg.sig_len == '0)
            len = LEN_W'(1);
        else if (cfg.sig_len > LEN_W'(MAX_SIG_BYTES))
            len = LEN_W'(MAX_SIG_BYTES);
        else
            len = cfg.sig_len;
        len_m1 = POS_W'(len - LEN_W'(1));
    end

    // Window bytes: entry 0 is the current byte, entry p is p bytes back
    always_comb
    begin
        win[0] = data_byte;
        for (int p = 1; p < MAX_SIG_BYTES; p++)
            win[p] = hist_reg[p-1];
        for (int j = 0; j < MAX_SIG_BYTES; j++)
            sig[j] = (j < 8) ? cfg.sig_low[(j % 8)*8 +: 8] : cfg.sig_high[(j % 8)*8 +: 8];
    end

    // Per-lane compare; signature byte j sits len-1-j bytes back
    always_comb
    begin
        lane_ok = '0;
        k       = '0;
        for (int j = 0; j < MAX_SIG_BYTES; j++)
        begin
            k = len_m1 - POS_W'(j);
            lane_ok[j] = (POS_W'(j) > len_m1) || cfg.wild_mask[j] || (win[k] == sig[j]);
        end
    end

    // Match, count, capture and address
    always_comb
    begin
        hit     = (pos_reg >= {{(32-POS_W){1'b0}}, len_m1}) && (&lane_ok);
        start   = hit ? (pos_reg - {{(32-POS_W){1'b0}}, len_m1}) : '0;
        capture = hit && !req_hit_reg && (cnt_reg == cfg.match_idx);

        cnt_next       = (hit && cnt_reg != MAX32) ? cnt_reg + 32'd1 : cnt_reg;
        pos_next       = (pos_reg != MAX32) ? pos_reg + 32'd1 : pos_reg;
        req_hit_next   = req_hit_reg || capture;
        req_start_next = capture ? start : req_start_reg;

        found = last_byte && req_hit_next;

        res.window_match      = hit;
        res.match_start       = start;
        res.matches_so_far    = cnt_next;
        res.end_of_buffer     = last_byte;
        res.requested_found   = found;
        res.requested_address = found ? cfg.addr_bias + req_start_next : '0;
    end

    // Byte history
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            hist_reg[0] <= data_byte;
            for (int p = 1; p < HIST_DEPTH; p++)
                hist_reg[p] <= hist_reg[p-1];
        end
    end

    // Per-buffer state, cleared after the last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            cnt_reg       <= '0;
            req_hit_reg   <= 1'b0;
            req_start_reg <= '0;
        end
        else if (step)
        begin
            if (last_byte)
            begin
                pos_reg       <= '0;
                cnt_reg       <= '0;
                req_hit_reg   <= 1'b0;
                req_start_reg <= '0;
            end
            else
            begin
                pos_reg       <= pos_next;
                cnt_reg       <= cnt_next;
                req_hit_reg   <= req_hit_next;
                req_start_reg <= req_start_next;
            end
        end
    end

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step && last_byte |=> pos_reg == '0 && cnt_reg == '0 && !req_hit_reg)
        else $error("buffer state not cleared after last item");

    a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(pos_reg) && $stable(cnt_reg) && $stable(req_hit_reg))
        else $error("buffer state moved without an item");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        step && !last_byte && hit && cnt_reg != MAX32 |=> cnt_reg == $past(cnt_reg) + 32'd1)
        else $error("match counter missed a match");

endmodule

// ----- sv/wildcard_byte_signature_scanner.sv -----
// Channel  Dir  Handshake      Payload
// stream   in   valid/ready    data_byte[7:0], last_byte
// result   out  valid/ready    window_match, match_start[31:0], matches_so_far[31:0],
//                              end_of_buffer, requested_found, requested_address[31:0]
// cfg      in   valid/ready    index[2:0], data[63:0] (ready always high)
//
// One item per cycle sustained while the result side does not stall; each item passes
// through the input register, then compare/count logic into the result register.
// All 16 signature lanes compare in parallel against a 15-byte history shift register.
// rst_n is asynchronous; it clears the pipeline valids, buffer state and registers.
// A stalled result holds both registers; the input side keeps accepting while either
// stage has room.
module wildcard_byte_signature_scanner (
    input  logic        clk,
    input  logic        rst_n,
    wbss_in_if.sink     stream,
    wbss_out_if.source  result,
    wbss_cfg_if.sink    cfg
);
    import wbss_pkg::*;

    cfg_t        cfg_q;
    res_t        res_calc;

    logic        in_vld_reg;
    logic [7:0]  in_data_reg;
    logic        in_last_reg;
    logic        res_vld_reg;
    res_t        res_reg;
    logic        advance;
    logic        take_in;

    assign cfg.ready = 1'b1;

    wbss_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg.valid),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .cfg      (cfg_q)
    );

    // Pipeline control
    assign advance      = in_vld_reg && (!res_vld_reg || result.ready);
    assign stream.ready = !in_vld_reg || advance;
    assign take_in      = stream.valid && stream.ready;

    wbss_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_q),
        .step      (advance),
        .data_byte (in_data_reg),
        .last_byte (in_last_reg),
        .res       (res_calc)
    );

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (take_in)
            in_vld_reg <= 1'b1;
        else if (advance)
            in_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            in_data_reg <= stream.data_byte;
            in_last_reg <= stream.last_byte;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_vld_reg <= 1'b0;
        else if (advance)
            res_vld_reg <= 1'b1;
        else if (result.ready)
            res_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= res_calc;
    end

    assign result.valid             = res_vld_reg;
    assign result.window_match      = res_reg.window_match;
    assign result.match_start       = res_reg.match_start;
    assign result.matches_so_far    = res_reg.matches_so_far;
    assign result.end_of_buffer     = res_reg.end_of_buffer;
    assign result.requested_found   = res_reg.requested_found;
    assign result.requested_address = res_reg.requested_address;

    a_fill_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_vld_reg && !res_vld_reg |=> res_vld_reg)
        else $error("item stuck in input register");

    a_found_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        res_vld_reg && res_reg.requested_found |-> res_reg.end_of_buffer)
        else $error("requested match reported before end of buffer");

    a_start_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_vld_reg && !res_reg.window_match |-> res_reg.match_start == '0)
        else $error("start reported without a match");

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
    import wbss_pkg::*;

    localparam int RANDOM_BYTES = 1000;
    localparam int MAX_REPORTS  = 40;
    localparam int DRAIN_LIMIT  = 2000;
    localparam int SETTLE       = 4;
    localparam int HOLD_OFF     = 60;

    logic clk = 1'b0;
    logic rst_n;

    wbss_in_if  stream_if ();
    wbss_out_if result_if ();
    wbss_cfg_if cfg_if ();

    wildcard_byte_signature_scanner dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream_if),
        .result (result_if),
        .cfg    (cfg_if)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Shadow copy of the registers
    logic [63:0]              sig_lo_q;
    logic [63:0]              sig_hi_q;
    logic [MAX_SIG_BYTES-1:0] wild_q;
    logic [LEN_W-1:0]         len_q;
    logic [31:0]              idx_q;
    logic [31:0]              ofs_q;
    logic [31:0]              base_q;

    // Shadow copy of the per-buffer scan state
    logic [7:0]  hist_q [HIST_DEPTH];
    logic [31:0] pos_q;
    logic [31:0] count_q;
    logic        hit_q;
    logic [31:0] hit_start_q;

    res_t expected_results [$];
    int   mismatch_count = 0;
    int   results_seen   = 0;
    int   bytes_sent     = 0;

    // Idle controls shared by the stream driver and the result sink
    int src_gap_max  = 0;
    int sink_gap_max = 0;
    int hold_cycles  = 0;

    function automatic void clear_scan();
        int i;
        for (i = 0; i < HIST_DEPTH; i++)
            hist_q[i] = 8'h00;
        pos_q       = '0;
        count_q     = '0;
        hit_q       = 1'b0;
        hit_start_q = '0;
    endfunction

    // Length zero behaves as one, anything above the lane count as full width
    function automatic int active_len();
        if (len_q == 0)
            return 1;
        if (len_q > MAX_SIG_BYTES)
            return MAX_SIG_BYTES;
        return int'(len_q);
    endfunction

    function automatic logic [7:0] sig_byte(int j);
        if (j < 8)
            return sig_lo_q[8*j +: 8];
        return sig_hi_q[8*(j-8) +: 8];
    endfunction

    // Advance the shadow scanner by one byte and return what the block should report
    function automatic res_t scan_byte(logic [7:0] data, logic is_last);
        res_t        r;
        int          len;
        int          j;
        int          k;
        logic [7:0]  b;
        logic        hit_now;
        logic [31:0] start;

        len     = active_len();
        hit_now = 1'b0;
        start   = '0;

        // window can only match once enough bytes of this buffer are in
        if (pos_q >= 32'(len - 1))
        begin
            hit_now = 1'b1;
            for (j = 0; j < len; j++)
            begin
                k = len - 1 - j;
                b = (k == 0) ? data : hist_q[k-1];
                if (!wild_q[j] && b != sig_byte(j))
                    hit_now = 1'b0;
            end
            if (hit_now)
                start = pos_q - 32'(len - 1);
        end

        if (hit_now)
        begin
            if (!hit_q && count_q == idx_q)
            begin
                hit_q       = 1'b1;
                hit_start_q = start;
            end
            if (count_q != '1)
                count_q++;
        end

        for (j = HIST_DEPTH - 1; j > 0; j--)
            hist_q[j] = hist_q[j-1];
        hist_q[0] = data;
        if (pos_q != '1)
            pos_q++;

        r.window_match      = hit_now;
        r.match_start       = start;
        r.matches_so_far    = count_q;
        r.end_of_buffer     = is_last;
        r.requested_found   = is_last && hit_q;
        r.requested_address = r.requested_found ? base_q + hit_start_q + ofs_q : '0;

        if (is_last)
            clear_scan();
        return r;
    endfunction

    task automatic flag_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // Register write; shadow copy follows at the accepting edge
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_if.valid = 1'b1;
        cfg_if.index = idx;
        cfg_if.data  = value;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        case (idx)
            REG_SIG_LOW:   sig_lo_q = value;
            REG_SIG_HIGH:  sig_hi_q = value;
            REG_WILDCARD:  wild_q   = value[MAX_SIG_BYTES-1:0];
            REG_SIG_LEN:   len_q    = value[LEN_W-1:0];
            REG_MATCH_IDX: idx_q    = value[31:0];
            REG_ADDR_OFS:  ofs_q    = value[31:0];
            REG_BASE:      base_q   = value[31:0];
            default:       ;
        endcase
        @(negedge clk);
        cfg_if.valid = 1'b0;
    endtask

    // Offer one byte item; prediction is made at the accepting edge
    task automatic send_byte(logic [7:0] data, logic is_last);
        int   gap;
        res_t pred;
        @(negedge clk);
        gap = $urandom_range(0, src_gap_max);
        if (gap > 0)
        begin
            stream_if.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        stream_if.valid     = 1'b1;
        stream_if.data_byte = data;
        stream_if.last_byte = is_last;
        do
            @(posedge clk);
        while (!stream_if.ready);
        pred = scan_byte(data, is_last);
        expected_results.insert(expected_results.size(), pred);
        bytes_sent++;
    endtask

    // Stop offering and wait until every predicted result is back
    task automatic wait_idle();
        int waited;
        @(negedge clk);
        stream_if.valid = 1'b0;
        waited = 0;
        while (expected_results.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (expected_results.size() != 0)
        begin
            flag_mismatch($sformatf("%0d results never arrived", expected_results.size()));
            expected_results.delete();
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic logic [63:0] pick_wide();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Result sink: random wait per item, or one long hold-off when requested
    initial
    begin : result_sink
        int n;
        result_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            n = (hold_cycles > 0) ? hold_cycles : $urandom_range(0, sink_gap_max);
            hold_cycles = 0;
            if (n > 0)
            begin
                result_if.ready = 1'b0;
                repeat (n) @(negedge clk);
            end
            result_if.ready = 1'b1;
            do
                @(posedge clk);
            while (!result_if.valid);
        end
    end

    // Compare each accepted result against the oldest prediction
    always @(posedge clk)
    begin : result_check
        res_t got;
        res_t want;
        if (rst_n && result_if.valid && result_if.ready)
        begin
            got.window_match      = result_if.window_match;
            got.match_start       = result_if.match_start;
            got.matches_so_far    = result_if.matches_so_far;
            got.end_of_buffer     = result_if.end_of_buffer;
            got.requested_found   = result_if.requested_found;
            got.requested_address = result_if.requested_address;
            if (expected_results.size() == 0)
                flag_mismatch($sformatf("result %0d arrived with nothing pending", results_seen));
            else
            begin
                want = expected_results.pop_front();
                if (got.window_match !== want.window_match)
                    flag_mismatch($sformatf("result %0d window_match %b, want %b",
                        results_seen, got.window_match, want.window_match));
                if (got.match_start !== want.match_start)
                    flag_mismatch($sformatf("result %0d match_start %h, want %h",
                        results_seen, got.match_start, want.match_start));
                if (got.matches_so_far !== want.matches_so_far)
                    flag_mismatch($sformatf("result %0d matches_so_far %h, want %h",
                        results_seen, got.matches_so_far, want.matches_so_far));
                if (got.end_of_buffer !== want.end_of_buffer)
                    flag_mismatch($sformatf("result %0d end_of_buffer %b, want %b",
                        results_seen, got.end_of_buffer, want.end_of_buffer));
                if (got.requested_found !== want.requested_found)
                    flag_mismatch($sformatf("result %0d requested_found %b, want %b",
                        results_seen, got.requested_found, want.requested_found));
                if (got.requested_address !== want.requested_address)
                    flag_mismatch($sformatf("result %0d requested_address %h, want %h",
                        results_seen, got.requested_address, want.requested_address));
            end
            results_seen++;
        end
    end

    // Reset values: single zero byte signature matches every zero byte
    task automatic test_reset_values();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        wait_idle();
    endtask

    // Full 16-byte signature, over-range length, wild end lanes, address wrap
    task automatic test_wide_signature();
        int j;
        write_reg(REG_SIG_LOW,   64'h8877665544332211);
        write_reg(REG_SIG_HIGH,  64'hFFEEDDCCBBAA0099);
        write_reg(REG_WILDCARD,  64'h8001);
        write_reg(REG_SIG_LEN,   64'd31);
        write_reg(REG_MATCH_IDX, 64'd0);
        write_reg(REG_BASE,      64'hFFFF_FFF0);
        write_reg(REG_ADDR_OFS,  64'h20);
        // short history: nothing may match before byte 15
        for (j = 0; j < MAX_SIG_BYTES; j++)
        begin
            if (j == 0)
                send_byte(8'h00, 1'b0);
            else if (j == MAX_SIG_BYTES - 1)
                send_byte(8'hFF, 1'b1);
            else
                send_byte(sig_byte(j), 1'b0);
        end
        wait_idle();
    endtask

    // Length zero acts as one; requested ordinal never reached
    task automatic test_length_and_index();
        write_reg(REG_SIG_LEN,   64'd0);
        write_reg(REG_WILDCARD,  64'h0);
        write_reg(REG_SIG_LOW,   64'hA5);
        write_reg(REG_MATCH_IDX, 64'hFFFF_FFFF);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'hA5, 1'b1);
        wait_idle();
    endtask

    // Signature changes while a buffer is open; capture from before survives
    task automatic test_mid_buffer_config();
        write_reg(REG_MATCH_IDX, 64'd0);
        send_byte(8'hA5, 1'b0);
        wait_idle();
        write_reg(REG_SIG_LOW, 64'h5A);
        send_byte(8'h5A, 1'b1);
        wait_idle();
    endtask

    // Result side stalls for a long stretch while bytes keep coming
    task automatic test_back_pressure();
        int n;
        write_reg(REG_SIG_LEN,   64'd2);
        write_reg(REG_WILDCARD,  64'hFFFF);
        write_reg(REG_MATCH_IDX, 64'd5);
        src_gap_max  = 0;
        sink_gap_max = 0;
        hold_cycles  = HOLD_OFF;
        for (n = 0; n < 40; n++)
            send_byte(8'($urandom), n == 39);
        wait_idle();
    endtask

    // New register set for a random phase; early phases hit the length extremes
    task automatic randomize_config(int phase);
        logic [63:0] len_val;
        logic [63:0] idx_val;
        logic [63:0] wild_val;
        case (phase)
            0:       len_val = 64'd1;
            1:       len_val = 64'd16;
            2:       len_val = 64'd0;
            3:       len_val = 64'd31;
            default: len_val = 64'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 31)
                                                               : $urandom_range(1, 16));
        endcase
        case ($urandom_range(0, 7))
            0:       idx_val = 64'd0;
            1:       idx_val = 64'hFFFF_FFFF;
            2:       idx_val = 64'($urandom);
            default: idx_val = 64'($urandom_range(0, 3));
        endcase
        case ($urandom_range(0, 5))
            0:       wild_val = 64'h0;
            1:       wild_val = 64'hFFFF;
            default: wild_val = 64'($urandom & $urandom & 32'hFFFF);
        endcase
        write_reg(REG_SIG_LOW,   pick_wide());
        write_reg(REG_SIG_HIGH,  pick_wide());
        write_reg(REG_WILDCARD,  wild_val);
        write_reg(REG_SIG_LEN,   len_val);
        write_reg(REG_MATCH_IDX, idx_val);
        write_reg(REG_ADDR_OFS,  64'(32'(pick_wide())));
        write_reg(REG_BASE,      64'(32'(pick_wide())));
    endtask

    // Buffers with planted signature copies, random fill and truncated tails
    task automatic test_random_buffers();
        int          phase;
        int          target;
        int          nbuf;
        int          buf_i;
        int          blen;
        int          n;
        int          eff_len;
        int          plant_pos;
        int          plant_odds;
        logic        close_buf;
        logic [7:0]  b;

        phase  = 0;
        target = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < target)
        begin
            wait_idle();
            randomize_config(phase);
            eff_len = active_len();
            case ($urandom_range(0, 3))
                0:       src_gap_max = 0;
                1:       src_gap_max = 6;
                default: src_gap_max = $urandom_range(1, 6);
            endcase
            case ($urandom_range(0, 3))
                0:       sink_gap_max = 0;
                1:       sink_gap_max = 6;
                default: sink_gap_max = $urandom_range(1, 6);
            endcase
            // a quarter of the phases are mostly plain noise
            plant_odds = ($urandom_range(0, 3) == 0) ? 1000 : $urandom_range(0, 6);
            nbuf = $urandom_range(2, 6);
            for (buf_i = 0; buf_i < nbuf; buf_i++)
            begin
                blen = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80)
                                                   : $urandom_range(1, 3 * eff_len + 4);
                // sometimes leave the buffer open across the next register update
                close_buf = !(buf_i == nbuf - 1 && $urandom_range(0, 3) == 0);
                plant_pos = -1;
                for (n = 0; n < blen; n++)
                begin
                    if (plant_pos < 0 && $urandom_range(0, plant_odds) == 0)
                        plant_pos = 0;
                    if (plant_pos >= 0)
                    begin
                        b = wild_q[plant_pos] ? 8'($urandom) : sig_byte(plant_pos);
                        plant_pos++;
                        if (plant_pos == eff_len)
                            plant_pos = -1;
                    end
                    else
                        b = 8'($urandom);
                    send_byte(b, close_buf && n == blen - 1);
                end
            end
            phase++;
        end
        wait_idle();
    endtask

    initial
    begin
        rst_n               = 1'b0;
        stream_if.valid     = 1'b0;
        stream_if.data_byte = 8'h00;
        stream_if.last_byte = 1'b0;
        cfg_if.valid        = 1'b0;
        cfg_if.index        = REG_SIG_LOW;
        cfg_if.data         = '0;

        // shadow copy starts from reset values
        sig_lo_q = '0;
        sig_hi_q = '0;
        wild_q   = '0;
        len_q    = 5'd1;
        idx_q    = '0;
        ofs_q    = '0;
        base_q   = '0;
        clear_scan();

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_values();
        test_wide_signature();
        test_length_and_index();
        test_mid_buffer_config();
        test_back_pressure();
        test_random_buffers();

        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Run limit
    initial
    begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

// ----- wildcard_byte_signature_scanner.f -----
sv/wbss_pkg.sv
sv/wbss_ifs.sv
sv/wbss_cfg.sv
sv/wbss_core.sv
sv/wildcard_byte_signature_scanner.sv
test/tb_top.sv
